// File: rtl/mfbp_pkg.sv
// Package for the motion frame byte packer: types, codes and constants
// shared by the controller, the datapath and the top level. No dependencies.
`timescale 1ns / 1ps

package mfbp_pkg;

  // item kinds
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_ANGLE  = 2'd1;
  localparam logic [1:0] KIND_TIMES  = 2'd2;
  localparam logic [1:0] KIND_FINISH = 2'd3;

  // frame types
  localparam logic [7:0] FTYPE_EDGE = 8'd1;
  localparam logic [7:0] FTYPE_MID  = 8'd2;
  localparam logic [7:0] FTYPE_ONLY = 8'd3;

  // byte positions within one 33-byte record
  localparam logic [5:0] POS_FIRST   = 6'd0;
  localparam logic [5:0] POS_SUM_LO  = 6'd2;
  localparam logic [5:0] HDR_LEN     = 6'd8;
  localparam logic [5:0] POS_ANG_END = 6'd27;
  localparam logic [5:0] POS_RUN     = 6'd28;
  localparam logic [5:0] POS_TOT_HI  = 6'd29;
  localparam logic [5:0] POS_TOT_LO  = 6'd30;
  localparam logic [5:0] POS_CSUM    = 6'd31;
  localparam logic [5:0] POS_LAST    = 6'd32;

  localparam logic [4:0] ANGLE_SLOTS = 5'd20;

  localparam logic [7:0] SYNC_0     = 8'hFB;
  localparam logic [7:0] SYNC_1     = 8'hBF;
  localparam logic [7:0] VERSION    = 8'h01;
  localparam logic [7:0] END_MARK   = 8'hED;
  localparam logic [7:0] FILL_ANGLE = 8'd90;
  localparam logic [7:0] BYTE_MAX   = 8'hFF;

  localparam logic [15:0] TIME_ADJ_MIN = 16'd60;
  localparam logic [15:0] TIME_ADJ     = 16'd40;
  localparam logic [5:0]  TICK_MS      = 6'd20;
  localparam logic [23:0] TIME_MAX     = 24'hFFFFFF;

  // x / 20 == (x * 52429) >> 20, exact for every 16-bit x
  localparam logic [15:0] DIV20_MUL = 16'd52429;

  localparam logic [15:0] FRAME_TOTAL_RST = 16'd1;
  localparam logic [15:0] FRAME_NUM_RST   = 16'd1;

  // register map
  localparam int          PADDR_W         = 3;
  localparam logic [2:0]  ADDR_FRAME_TOTAL = 3'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV_RUN,
    ST_DIV_TOT,
    ST_FIXUP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic clear;
    logic div_run;
    logic div_tot;
    logic fixup;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       angles_full;
    logic       last_pos;
    logic       out_free;
  } status_t;

endpackage

// File: rtl/mfbp_item_if.sv
// Input channel of the byte packer: valid/ready handshake and one item.
// Depends on nothing.
`timescale 1ns / 1ps

interface mfbp_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  servo_angle;
  logic [12:0] run_time;
  logic [15:0] total_time;

  modport source (output valid, kind, servo_angle, run_time, total_time, input ready);
  modport sink   (input valid, kind, servo_angle, run_time, total_time, output ready);
endinterface

// File: rtl/mfbp_byte_if.sv
// Output channel of the byte packer: valid/ready handshake and one stream byte.
// Depends on nothing.
`timescale 1ns / 1ps

interface mfbp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// File: rtl/mfbp_ctrl.sv
// Controller of the byte packer: sequences capture, divide steps and byte output.
// Depends on mfbp_pkg.
`timescale 1ns / 1ps

module mfbp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  mfbp_pkg::status_t status,
  output mfbp_pkg::cmd_t    cmd
);
  import mfbp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        cmd.clear = (status.kind == KIND_START);
        // a surplus angle produces nothing
        if (status.kind == KIND_ANGLE && status.angles_full) begin
          state_next = ST_IDLE;
        end else if (status.kind == KIND_TIMES) begin
          state_next = ST_DIV_RUN;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_DIV_RUN: begin
        cmd.div_run = 1'b1;
        state_next  = ST_DIV_TOT;
      end
      ST_DIV_TOT: begin
        cmd.div_tot = 1'b1;
        state_next  = ST_FIXUP;
      end
      ST_FIXUP: begin
        cmd.fixup  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_pos) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/mfbp_dp.sv
// Datapath of the byte packer: item capture, frame state, divide-by-20 unit,
// byte selection and the output word register. Depends on mfbp_pkg.
`timescale 1ns / 1ps

module mfbp_dp (
  input  logic              clk,
  input  logic              rst,
  input  mfbp_pkg::cmd_t    cmd,
  output mfbp_pkg::status_t status,
  input  logic [15:0]       frame_total,
  input  logic [1:0]        kind,
  input  logic [7:0]        servo_angle,
  input  logic [12:0]       run_time,
  input  logic [15:0]       total_time,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              last_byte
);
  import mfbp_pkg::*;

  // captured item
  logic [1:0]  kind_q;
  logic [7:0]  angle_q;
  logic [12:0] run_q;
  logic [15:0] tot_q;

  // frame state
  logic [15:0] frame_number;
  logic [4:0]  angles_done;
  logic        header_done;
  logic [7:0]  sum_acc;
  logic [4:0]  remainder_short;
  logic [4:0]  remainder_long;
  logic [23:0] time_total;

  // sequencing and time working registers
  logic [5:0]  pos;
  logic [5:0]  end_pos;
  logic [15:0] t_adj;
  logic [7:0]  run_div;
  logic [11:0] tot_div;
  logic [7:0]  time_hi;
  logic [7:0]  time_lo;

  logic [5:0]  start_pos;
  logic [5:0]  end_sel;
  logic [15:0] mul_a;
  logic [31:0] mul_p;
  logic [15:0] q20;
  logic [15:0] rem_full;
  logic        is_short;
  logic [4:0]  rem_cur;
  logic [5:0]  rem_sum;
  logic [4:0]  rem_next;
  logic [7:0]  hi_next;
  logic [7:0]  lo_next;
  logic [7:0]  ftype;
  logic [7:0]  byte_sel;
  logic        is_frame;
  logic [24:0] time_sum;

  assign is_frame = (kind_q == KIND_ANGLE) || (kind_q == KIND_TIMES);

  assign status.kind        = kind_q;
  assign status.angles_full = (angles_done >= ANGLE_SLOTS);
  assign status.last_pos    = (pos == end_pos);
  assign status.out_free    = !out_valid || out_ready;

  // resume where the open frame left off; start and trailer records run in full
  assign start_pos = (is_frame && header_done) ? ({1'b0, angles_done} + HDR_LEN) : POS_FIRST;
  assign end_sel   = (kind_q == KIND_ANGLE) ? ({1'b0, angles_done} + HDR_LEN) : POS_LAST;

  // one shared multiplier for both divisions by 20
  assign mul_a = cmd.div_run ? {3'b0, run_q} : t_adj;
  assign mul_p = mul_a * DIV20_MUL;

  // remainder carry and the wrap rules on the total time bytes
  always_comb begin
    q20      = {tot_div, 4'b0} + {2'b0, tot_div, 2'b0};
    rem_full = t_adj - q20;
    is_short = (tot_div[11:8] == 4'd0);
    rem_cur  = is_short ? remainder_short : remainder_long;
    rem_sum  = {1'b0, rem_cur} + {1'b0, rem_full[4:0]};
    hi_next  = is_short ? 8'd0 : {4'b0, tot_div[11:8]};
    lo_next  = tot_div[7:0];
    rem_next = rem_sum[4:0];
    if (rem_sum >= TICK_MS) begin
      rem_next = 5'(rem_sum - TICK_MS);
      lo_next  = lo_next + 8'd1;
    end
    if (lo_next == BYTE_MAX) begin
      hi_next = hi_next + 8'd1;
      lo_next = 8'd0;
    end else if (lo_next == 8'd0) begin
      lo_next = 8'd1;
    end
  end

  always_comb begin
    if (frame_number == FRAME_NUM_RST) begin
      ftype = (frame_total == FRAME_TOTAL_RST) ? FTYPE_ONLY : FTYPE_EDGE;
    end else if (frame_number == frame_total) begin
      ftype = FTYPE_EDGE;
    end else begin
      ftype = FTYPE_MID;
    end
  end

  always_comb begin
    byte_sel = 8'd0;
    case (kind_q)
      KIND_START: begin
        byte_sel = 8'd0;
      end
      KIND_FINISH: begin
        case (pos)
          POS_TOT_HI: byte_sel = time_total[7:0];
          POS_TOT_LO: byte_sel = time_total[15:8];
          POS_CSUM:   byte_sel = time_total[23:16];
          default:    byte_sel = 8'd0;
        endcase
      end
      default: begin
        case (pos) inside
          6'd0:       byte_sel = SYNC_0;
          6'd1:       byte_sel = SYNC_1;
          6'd2:       byte_sel = VERSION;
          6'd3:       byte_sel = ftype;
          6'd4:       byte_sel = frame_total[7:0];
          6'd5:       byte_sel = frame_total[15:8];
          6'd6:       byte_sel = frame_number[7:0];
          6'd7:       byte_sel = frame_number[15:8];
          [6'd8:6'd27]: byte_sel = (kind_q == KIND_ANGLE) ? angle_q : FILL_ANGLE;
          POS_RUN:    byte_sel = run_div;
          POS_TOT_HI: byte_sel = time_hi;
          POS_TOT_LO: byte_sel = time_lo;
          POS_CSUM:   byte_sel = sum_acc;
          POS_LAST:   byte_sel = END_MARK;
          default:    byte_sel = 8'd0;
        endcase
      end
    endcase
  end

  assign time_sum = {1'b0, time_total} + {9'b0, tot_q};

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q  <= kind;
      angle_q <= servo_angle;
      run_q   <= run_time;
      tot_q   <= total_time;
    end
    if (cmd.load) begin
      pos     <= start_pos;
      end_pos <= end_sel;
      t_adj   <= (tot_q >= TIME_ADJ_MIN) ? (tot_q - TIME_ADJ) : tot_q;
    end
    if (cmd.div_run) begin
      run_div <= mul_p[27:20];
    end
    if (cmd.div_tot) begin
      tot_div <= mul_p[31:20];
    end
    if (cmd.fixup) begin
      time_hi <= hi_next;
      time_lo <= lo_next;
    end
    if (cmd.emit) begin
      out_byte  <= byte_sel;
      last_byte <= status.last_pos;
      pos       <= pos + 6'd1;
    end
  end

  // frame state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      frame_number    <= FRAME_NUM_RST;
      angles_done     <= 5'd0;
      header_done     <= 1'b0;
      sum_acc         <= 8'd0;
      remainder_short <= 5'd0;
      remainder_long  <= 5'd0;
      time_total      <= 24'd0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.clear) begin
        frame_number    <= FRAME_NUM_RST;
        angles_done     <= 5'd0;
        header_done     <= 1'b0;
        sum_acc         <= 8'd0;
        remainder_short <= 5'd0;
        remainder_long  <= 5'd0;
        time_total      <= 24'd0;
      end

      if (cmd.fixup) begin
        if (is_short) begin
          remainder_short <= rem_next;
        end else begin
          remainder_long <= rem_next;
        end
      end

      if (cmd.emit && is_frame) begin
        header_done <= 1'b1;
        if (pos == POS_FIRST) begin
          sum_acc <= 8'd0;
        end else if (pos >= POS_SUM_LO && pos <= POS_TOT_LO) begin
          sum_acc <= sum_acc + byte_sel;
        end
        if (pos >= HDR_LEN && pos <= POS_ANG_END) begin
          angles_done <= angles_done + 5'd1;
        end
        // close the frame on its end mark
        if (kind_q == KIND_TIMES && status.last_pos) begin
          frame_number <= frame_number + 16'd1;
          angles_done  <= 5'd0;
          header_done  <= 1'b0;
          sum_acc      <= 8'd0;
          time_total   <= time_sum[24] ? TIME_MAX : time_sum[23:0];
        end
      end
    end
  end

endmodule

// File: rtl/motion_frame_byte_packer_top.sv
// Top level of the motion frame byte packer: channels, register port, controller
// and datapath. Depends on mfbp_pkg, mfbp_item_if, mfbp_byte_if, mfbp_ctrl, mfbp_dp.
//
//   channel  direction  word                                        handshake
//   item     in         kind, servo_angle, run_time, total_time      valid/ready
//   result   out        out_byte, last_byte                          valid/ready
//   apb      in         frame_total at byte address 0                psel/penable
//
// One item at a time: accept, a decode state, then one byte per cycle from the
// output register while the result side takes them. Start and finish emit a full
// 33-byte record, an angle 9 bytes or 1 (none if the frame is full), a times item
// the run and total divide-by-20 steps and a fixup, then 5 to 33 bytes. A result
// stall holds the sequencer; the next item is taken while the last byte still waits.
// Reset is synchronous and sets frame_total to 1 and the frame state to its start.
`timescale 1ns / 1ps

module motion_frame_byte_packer_top (
  input  logic                          clk,
  input  logic                          rst,
  mfbp_item_if.sink                     item,
  mfbp_byte_if.source                   result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mfbp_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import mfbp_pkg::*;

  cmd_t        cmd;
  status_t     status;
  logic [15:0] frame_total;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_FRAME_TOTAL) ? {16'd0, frame_total} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_total <= FRAME_TOTAL_RST;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_FRAME_TOTAL) begin
      frame_total <= pwdata[15:0];
    end
  end

  mfbp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  mfbp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .frame_total (frame_total),
    .kind        (item.kind),
    .servo_angle (item.servo_angle),
    .run_time    (item.run_time),
    .total_time  (item.total_time),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_byte    (result.out_byte),
    .last_byte   (result.last_byte)
  );

endmodule

// File: dv/mfbp_byte_stream_checker.sv
// Byte stream checker for the motion frame byte packer: watches the item,
// result and register ports, predicts every stream byte and compares in order.
// Depends on mfbp_pkg, mfbp_item_if and mfbp_byte_if.
`timescale 1ns / 1ps

module mfbp_byte_stream_checker (
  input  logic                         clk,
  input  logic                         rst,
  mfbp_item_if                         item,
  mfbp_byte_if                         result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [mfbp_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output int                           fails,
  output int                           pending
);
  import mfbp_pkg::*;

  localparam int REC_BYTES  = 33;
  localparam int TRL_TIME_0 = 29;
  localparam int TRL_TIME_1 = 30;
  localparam int TRL_TIME_2 = 31;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  stream_byte_t due_bytes[$];

  logic [15:0] ft_reg;
  logic [15:0] fnum;
  logic [4:0]  n_angles;
  logic        hdr_open;
  logic [7:0]  csum;
  logic [4:0]  rem_short;
  logic [4:0]  rem_long;
  logic [23:0] ms_total;

  task automatic push_byte(input logic [7:0] b, input logic summed);
    stream_byte_t w;
    if (summed) csum = csum + b;
    w.data = b;
    w.last = 1'b0;
    due_bytes.push_back(w);
  endtask

  task automatic clear_frames();
    fnum      = FRAME_NUM_RST;
    n_angles  = '0;
    hdr_open  = 1'b0;
    csum      = '0;
    rem_short = '0;
    rem_long  = '0;
    ms_total  = '0;
  endtask

  task automatic emit_header();
    logic [7:0] ftype;
    if (fnum == 16'd1) ftype = (ft_reg == 16'd1) ? FTYPE_ONLY : FTYPE_EDGE;
    else if (fnum == ft_reg) ftype = FTYPE_EDGE;
    else ftype = FTYPE_MID;
    csum = '0;
    push_byte(SYNC_0, 1'b0);
    push_byte(SYNC_1, 1'b0);
    push_byte(VERSION, 1'b1);
    push_byte(ftype, 1'b1);
    push_byte(ft_reg[7:0], 1'b1);
    push_byte(ft_reg[15:8], 1'b1);
    push_byte(fnum[7:0], 1'b1);
    push_byte(fnum[15:8], 1'b1);
    hdr_open = 1'b1;
  endtask

  task automatic emit_times(input logic [12:0] run_ms, input logic [15:0] tot_ms);
    logic [15:0] runq;
    logic [15:0] t;
    logic [15:0] q;
    logic [15:0] rr;
    logic [5:0]  acc;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic        use_long;
    runq = {3'b000, run_ms} / 16'd20;
    push_byte(runq[7:0], 1'b1);
    t = tot_ms;
    if (t >= 16'd60) t = t - 16'd40;
    q  = t / 16'd20;
    rr = t % 16'd20;
    use_long = (q >= 16'd256);
    hi = use_long ? q[15:8] : 8'd0;
    lo = q[7:0];
    // carry the sub-tick remainder of the matching range into the low byte
    acc = (use_long ? {1'b0, rem_long} : {1'b0, rem_short}) + {1'b0, rr[4:0]};
    if (acc >= 6'd20) begin
      acc = acc - 6'd20;
      lo  = lo + 8'd1;
    end
    if (use_long) rem_long = acc[4:0];
    else rem_short = acc[4:0];
    if (lo == 8'hFF) begin
      hi = hi + 8'd1;
      lo = 8'd0;
    end else if (lo == 8'd0) begin
      lo = 8'd1;
    end
    push_byte(hi, 1'b1);
    push_byte(lo, 1'b1);
    push_byte(csum, 1'b0);
    push_byte(END_MARK, 1'b0);
  endtask

  task automatic pack_item(input logic [1:0] kind, input logic [7:0] angle,
                           input logic [12:0] run_ms, input logic [15:0] tot_ms);
    int           before_n;
    int           i;
    logic [24:0]  sum;
    logic [7:0]   b;
    stream_byte_t w;
    before_n = due_bytes.size();
    case (kind)
      KIND_START: begin
        clear_frames();
        for (i = 0; i < REC_BYTES; i++) push_byte(8'd0, 1'b0);
      end
      KIND_ANGLE: begin
        // drop angles beyond the slot count
        if (n_angles < ANGLE_SLOTS) begin
          if (!hdr_open) emit_header();
          push_byte(angle, 1'b1);
          n_angles = n_angles + 5'd1;
        end
      end
      KIND_TIMES: begin
        if (!hdr_open) emit_header();
        while (n_angles < ANGLE_SLOTS) begin
          push_byte(FILL_ANGLE, 1'b1);
          n_angles = n_angles + 5'd1;
        end
        emit_times(run_ms, tot_ms);
        sum      = {1'b0, ms_total} + {9'd0, tot_ms};
        ms_total = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[23:0];
        fnum     = fnum + 16'd1;
        n_angles = '0;
        hdr_open = 1'b0;
        csum     = '0;
      end
      KIND_FINISH: begin
        for (i = 0; i < REC_BYTES; i++) begin
          b = 8'd0;
          if (i == TRL_TIME_0) b = ms_total[7:0];
          else if (i == TRL_TIME_1) b = ms_total[15:8];
          else if (i == TRL_TIME_2) b = ms_total[23:16];
          push_byte(b, 1'b0);
        end
      end
    endcase
    if (due_bytes.size() > before_n) begin
      w = due_bytes.pop_back();
      w.last = 1'b1;
      due_bytes.push_back(w);
    end
  endtask

  always @(posedge clk) begin : watch
    stream_byte_t want;
    if (rst) begin
      ft_reg = FRAME_TOTAL_RST;
      clear_frames();
      due_bytes.delete();
      fails = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_FRAME_TOTAL)
        ft_reg = pwdata[15:0];
      if (item.valid && item.ready)
        pack_item(item.kind, item.servo_angle, item.run_time, item.total_time);
      if (result.valid && result.ready) begin
        if (due_bytes.size() == 0) begin
          $error("unexpected word: out_byte 0x%02h last_byte %0b",
                 result.out_byte, result.last_byte);
          fails++;
        end else begin
          want = due_bytes.pop_front();
          if (result.out_byte !== want.data) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, result.out_byte);
            fails++;
          end
          if (result.last_byte !== want.last) begin
            $error("last_byte: expected %0b, actual %0b", want.last, result.last_byte);
            fails++;
          end
        end
      end
    end
    pending = due_bytes.size();
  end

endmodule

// File: dv/motion_frame_byte_packer_top_tb.sv
// Top of the byte packer testbench: clock, reset, item and register stimulus,
// result back-pressure, watchdog and verdict.
// Depends on mfbp_pkg, the channel interfaces, the block and mfbp_byte_stream_checker.
`timescale 1ns / 1ps

module motion_frame_byte_packer_top_tb;
  import mfbp_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_CYCLES  = 60;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_ITEMS   = 10;
  localparam int RAND_PHASES   = 5;
  localparam int SAT_TIMES     = 260;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  int fails;
  int pending;
  int idle_cycles = 0;
  int burst_left;
  bit hold_req;

  mfbp_item_if item_ch();
  mfbp_byte_if byte_ch();

  motion_frame_byte_packer_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (byte_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mfbp_byte_stream_checker u_chk (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (byte_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .fails   (fails),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sender: bursts of random length, random gaps; call and return on a falling edge
  task automatic send_item(input logic [1:0] k, input logic [7:0] a,
                           input logic [12:0] rt, input logic [15:0] tt);
    if (burst_left <= 0) begin
      item_ch.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
    item_ch.valid       = 1'b1;
    item_ch.kind        = k;
    item_ch.servo_angle = a;
    item_ch.run_time    = rt;
    item_ch.total_time  = tt;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
    burst_left--;
  endtask

  function automatic logic [12:0] rand_run();
    if ($urandom_range(0, 4) == 0) return 13'($urandom_range(5101, 8191));
    return 13'($urandom_range(0, 5100));
  endfunction

  function automatic logic [15:0] rand_total();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, 120));
      1:       return 16'($urandom_range(5130, 5170));
      2:       return 16'($urandom_range(65000, 65535));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_angles(input int n);
    int i;
    for (i = 0; i < n; i++)
      send_item(KIND_ANGLE, 8'($urandom_range(0, 255)), rand_run(), rand_total());
  endtask

  task automatic send_frame(input int n);
    send_angles(n);
    send_item(KIND_TIMES, 8'($urandom_range(0, 255)), rand_run(), rand_total());
  endtask

  // hold the item channel until every word has left and the block has gone quiet
  task automatic settle();
    item_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_total(input logic [15:0] val);
    logic [31:0] junk;
    junk    = $urandom();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_FRAME_TOTAL;
    pwdata  = {junk[31:16], val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic random_run(input int target);
    int count;
    int pick;
    int n;
    count = 0;
    while (count < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(21, 24) : $urandom_range(0, 20);
        send_frame(n);
        count += ((n > 20) ? 20 : n) + 1;
      end else if (pick < 80) begin
        // broken frame: cut short by a finish or a fresh start
        n = $urandom_range(1, 19);
        send_angles(n);
        send_item(($urandom_range(0, 1) == 0) ? KIND_FINISH : KIND_START,
                  8'($urandom_range(0, 255)), rand_run(), rand_total());
        count += n + 1;
      end else if (pick < 88) begin
        send_item(KIND_FINISH, 8'($urandom_range(0, 255)), rand_run(), rand_total());
        count++;
      end else if (pick < 92) begin
        send_item(KIND_START, 8'($urandom_range(0, 255)), rand_run(), rand_total());
        count++;
      end else begin
        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  rand_run(), rand_total());
        count++;
      end
    end
  endtask

  function automatic logic [15:0] phase_total(input int phase);
    case (phase)
      0:       return 16'd65535;
      1:       return 16'd2;
      2:       return 16'd3;
      3:       return 16'd1;
      default: return 16'($urandom_range(4, 65534));
    endcase
  endfunction

  // receiver: its own stall pattern, plus one long hold-off on request
  initial begin : receiver
    int  mode;
    int  cnt;
    int  period;
    bit  held;
    byte_ch.ready = 1'b0;
    mode   = 0;
    cnt    = 0;
    period = 3;
    held   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        byte_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (cnt % 64 == 0) begin
        mode   = $urandom_range(0, 2);
        period = $urandom_range(2, 5);
      end
      case (mode)
        0:       byte_ch.ready = 1'b1;
        1:       byte_ch.ready = ($urandom_range(0, 9) < 7);
        default: byte_ch.ready = (cnt % period != 0);
      endcase
      cnt++;
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (byte_ch.valid && byte_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[motion_frame_byte_packer_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int phase;
    int i;
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    item_ch.valid       = 1'b0;
    item_ch.kind        = KIND_START;
    item_ch.servo_angle = '0;
    item_ch.run_time    = '0;
    item_ch.total_time  = '0;
    burst_left          = 0;
    hold_req            = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: frame count left at its reset value
    send_item(KIND_FINISH, 8'd0, 13'd0, 16'd0);
    send_item(KIND_START, 8'hFF, 13'h1FFF, 16'hFFFF);
    send_item(KIND_ANGLE, 8'd0, 13'd0, 16'd0);
    send_item(KIND_ANGLE, 8'd255, 13'd0, 16'd0);
    send_item(KIND_TIMES, 8'd0, 13'd0, 16'd0);
    send_item(KIND_TIMES, 8'd0, 13'd8191, 16'd5150);
    send_item(KIND_TIMES, 8'd0, 13'd5100, 16'd65535);
    send_item(KIND_TIMES, 8'd0, 13'd19, 16'd59);
    send_item(KIND_TIMES, 8'd0, 13'd20, 16'd60);
    send_item(KIND_TIMES, 8'd0, 13'd5119, 16'd5159);
    send_item(KIND_ANGLE, 8'd7, 13'd0, 16'd0);
    send_item(KIND_FINISH, 8'd0, 13'd0, 16'd0);
    send_item(KIND_TIMES, 8'd0, 13'd1000, 16'd1234);
    send_item(KIND_FINISH, 8'd0, 13'd0, 16'd0);
    send_item(KIND_START, 8'd0, 13'd0, 16'd0);

    for (phase = 0; phase < RAND_PHASES; phase++) begin
      settle();
      write_total(phase_total(phase));
      send_item(KIND_START, 8'($urandom_range(0, 255)), rand_run(), rand_total());
      if (phase == 0) hold_req = 1'b1;
      random_run(PHASE_ITEMS);
    end

    // drive the time sum into saturation with short, long-timed frames
    settle();
    write_total(16'd200);
    send_item(KIND_START, 8'd0, 13'd0, 16'd0);
    for (i = 0; i < SAT_TIMES; i++) begin
      if ($urandom_range(0, 15) == 0) send_angles($urandom_range(1, 2));
      send_item(KIND_TIMES, 8'($urandom_range(0, 255)), rand_run(),
                16'($urandom_range(65200, 65535)));
    end
    send_item(KIND_FINISH, 8'd0, 13'd0, 16'd0);
    send_item(KIND_TIMES, 8'd0, 13'd0, 16'hFFFF);
    send_item(KIND_FINISH, 8'd0, 13'd0, 16'd0);

    item_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("[motion_frame_byte_packer_top] OK");
    end else begin
      $display("[motion_frame_byte_packer_top] ERROR");
    end
    $finish;
  end

endmodule
